>>> sv/lane_change_safe_gap_checker_unit_defines.svh
// ----------------------------------------------------------------------------
// Lane change safe gap checker: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LANE_CHANGE_SAFE_GAP_CHECKER_UNIT_DEFINES_SVH
`define LANE_CHANGE_SAFE_GAP_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define LCSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/lcsg_pkg.sv
// ----------------------------------------------------------------------------
// Lane change safe gap checker: package
// Item types, job record passed from front to back, and register indexes.
// ----------------------------------------------------------------------------
package lcsg_pkg;

	localparam int TERM_W = 24;   // linear kinematic terms
	localparam int VEL_W  = 20;   // doubled end speeds and their difference
	localparam int NUM_W  = 48;   // safe gap numerator

	typedef enum logic [0:0] {
		REG_EGO_SPEED = 1'b0,
		REG_EGO_ACCEL = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         zone;
		logic [15:0]        target_id;
		logic signed [23:0] target_gap;
		logic signed [15:0] target_speed;
		logic signed [15:0] target_accel;
		logic signed [23:0] target_pos_x;
		logic               last_target;
	} target_t;

	typedef struct packed {
		logic               danger;
		logic               safe_gap_valid;
		logic signed [23:0] safe_gap;
		logic               list_done;
		logic               warn_flag;
		logic [15:0]        warn_id;
	} result_t;

	// how the back end evaluates an item
	typedef enum logic [6:0] {
		K_NONE    = 7'b0000001,
		K_Z0      = 7'b0000010,
		K_Z1_FIX  = 7'b0000100,
		K_Z1_LIN  = 7'b0001000,
		K_Z1_QUAD = 7'b0010000,
		K_Z2_LIN  = 7'b0100000,
		K_Z2_QUAD = 7'b1000000
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [15:0]              target_id;
		logic signed [23:0]       gap;
		logic [23:0]              abs_pos;
		logic                     last;
		logic signed [TERM_W-1:0] base8;
		logic signed [VEL_W-1:0]  vt2;
		logic signed [VEL_W-1:0]  ve2;
		logic                     near_ok;     // gap under 30 m or short time to collision
		logic                     fix_danger;  // zone 1 receding case: gap under 50 m
	} job_t;

endpackage

>>> sv/lcsg_front.sv
// ----------------------------------------------------------------------------
// Lane change safe gap checker: front end
// Classifies an incoming target and forms its linear terms and gating tests.
// ----------------------------------------------------------------------------
module lcsg_front import lcsg_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  target_t            target,
	input  logic signed [15:0] ego_speed,
	input  logic signed [15:0] ego_accel,
	output job_t               job
);

	localparam int ONE = 1 << FRAC_BITS;
	localparam logic signed [TERM_W-1:0] K12   = TERM_W'(12);
	localparam logic signed [TERM_W-1:0] K9    = TERM_W'(9);
	localparam logic signed [TERM_W-1:0] C87   = TERM_W'(87 * ONE);
	localparam logic signed [TERM_W-1:0] C24   = TERM_W'(24 * ONE);
	localparam logic signed [VEL_W-1:0]  K3    = VEL_W'(3);
	localparam logic signed [23:0]       GAP30 = 24'(30 * ONE);
	localparam logic signed [23:0]       GAP50 = 24'(50 * ONE);
	localparam logic signed [25:0]       K15S  = 26'(15);
	localparam logic [25:0]              K15U  = 26'(15);

	logic signed [TERM_W-1:0] u, b, v, a;
	logic signed [TERM_W-1:0] lin_z0, lin_z1, lin_z2;
	logic signed [VEL_W-1:0]  vt2, ve2;
	logic signed [16:0]       den;
	logic [16:0]              aden;
	logic signed [23:0]       d;
	logic signed [24:0]       d25;
	logic [24:0]              ad;
	logic                     ttc1, ttc2;
	logic signed [25:0]       d2s, den15s;

	assign u = TERM_W'(target.target_speed);
	assign b = TERM_W'(target.target_accel);
	assign v = TERM_W'(ego_speed);
	assign a = TERM_W'(ego_accel);
	assign d = target.target_gap;

	assign lin_z0 = C87 + v * K12 + a * K9 - u * K12;
	assign lin_z1 = C24 + v * K12 + a * K9 - u * K12 - b * K9;
	assign lin_z2 = C24 - v * K12 - a * K9 + u * K12 + b * K9;

	assign vt2 = (VEL_W'(target.target_speed) <<< 1) + VEL_W'(target.target_accel) * K3;
	assign ve2 = (VEL_W'(ego_speed) <<< 1) + VEL_W'(ego_accel) * K3;

	assign den  = 17'(target.target_speed) - 17'(ego_speed);
	assign aden = den[16] ? 17'(-den) : 17'(den);
	assign d25  = 25'(d);
	assign ad   = d25[24] ? 25'(-d25) : 25'(d25);

	// zone 1: |gap| < 7.5 * |closing speed|
	assign ttc1 = (den != 17'sd0) && ({1'b0, ad} << 1 < 26'(aden) * K15U);

	// zone 2: gap / closing speed < 7.5 by cross multiplication
	assign d2s    = 26'(d) <<< 1;
	assign den15s = 26'(den) * K15S;
	always_comb begin
		priority if (den > 17'sd0)
			ttc2 = d2s < den15s;
		else if (den < 17'sd0)
			ttc2 = d2s > den15s;
		else
			ttc2 = d < 24'sd0;
	end

	always_comb begin
		job.target_id  = target.target_id;
		job.gap        = d;
		job.abs_pos    = target.target_pos_x[23] ? 24'(-target.target_pos_x)
		                                         : 24'(target.target_pos_x);
		job.last       = target.last_target;
		job.vt2        = vt2;
		job.ve2        = ve2;
		job.fix_danger = d < GAP50;
		job.near_ok    = 1'b0;
		job.base8      = '0;
		job.kind       = K_NONE;
		unique case (target.zone)
			2'd0: begin
				job.kind  = K_Z0;
				job.base8 = lin_z0;
			end
			2'd1: begin
				job.base8   = lin_z1;
				job.near_ok = (d < GAP30) || ttc1;
				if (target.target_speed < 16'sd0)
					job.kind = K_Z1_FIX;
				else if (vt2 > ve2)
					job.kind = K_Z1_LIN;
				else
					job.kind = K_Z1_QUAD;
			end
			2'd2: begin
				job.base8   = lin_z2;
				job.near_ok = (d < GAP30) || ttc2;
				job.kind    = (vt2 < ve2) ? K_Z2_LIN : K_Z2_QUAD;
			end
			default: job.kind = K_NONE;
		endcase
	end

endmodule

>>> sv/lcsg_queue.sv
// ----------------------------------------------------------------------------
// Lane change safe gap checker: job queue
// Small first-in first-out buffer of classified jobs between front and back.
// ----------------------------------------------------------------------------
module lcsg_queue import lcsg_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	output logic full,
	input  logic rd_en,
	output job_t rd_data,
	output logic not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full      = count_q == FULL_CNT;
	assign not_empty = count_q != '0;
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> sv/lcsg_back.sv
// ----------------------------------------------------------------------------
// Lane change safe gap checker: back end
// Sequencer with a shared squarer, gap compare, rounding divider, list
// tracking and the result register.
// ----------------------------------------------------------------------------
module lcsg_back import lcsg_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    job,
	input  logic    job_valid,
	output logic    job_pop,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	localparam int ONE       = 1 << FRAC_BITS;
	localparam int PW        = 2 * VEL_W;
	localparam logic signed [NUM_W-1:0] C5    = NUM_W'(5);
	localparam logic signed [NUM_W-1:0] C10   = NUM_W'(10);
	localparam logic signed [NUM_W-1:0] C35   = NUM_W'(35);
	localparam logic signed [NUM_W-1:0] C72   = NUM_W'(72);
	localparam logic signed [NUM_W-1:0] C80   = NUM_W'(80);
	localparam logic signed [NUM_W-1:0] C252  = NUM_W'(252);
	localparam logic signed [NUM_W-1:0] C280  = NUM_W'(280);
	localparam logic signed [NUM_W-1:0] H40   = NUM_W'(40 * ONE);
	localparam logic signed [NUM_W-1:0] H140  = NUM_W'(140 * ONE);
	localparam logic signed [NUM_W-1:0] MAX24 = NUM_W'(8388607);
	localparam logic signed [NUM_W-1:0] MIN24 = -NUM_W'(8388608);
	localparam logic signed [23:0]      GAP100 = 24'(100 * ONE);
	// floor(n / 35) and floor(n / 5) by reciprocal multiply, exact for n below 2^30
	localparam logic [30:0]             RCP35 = 31'd1963413622;   // ceil(2^36 / 35)
	localparam logic [30:0]             RCP5  = 31'd214748365;    // ceil(2^30 / 5)

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SQ1  = 7'b0000010,
		S_SQ2  = 7'b0000100,
		S_NUM  = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	job_t                     job_q;
	logic signed [PW-1:0]     p1_q, p2_q;
	logic signed [NUM_W-1:0]  num_q;
	logic                     danger_q, valid_q, neg_q;
	logic signed [23:0]       gap_q;
	logic [29:0]              divn_q;
	logic                     div_z1_q;
	logic                     out_valid_q;
	result_t                  out_q;
	logic                     seen_q;
	logic [23:0]              best_pos_q;
	logic [15:0]              best_id_q, held_q;

	// shared squarer
	logic signed [VEL_W-1:0]  w, mul_op;
	logic signed [PW-1:0]     mul_x, mul_p;
	// numerator and compare
	logic signed [NUM_W-1:0]  b48, ve48, w48, num_n, d48, lhs, r8, xr, yr;
	logic [NUM_W-1:0]         m, lim;
	logic                     quad, z1q, cmp, danger_n, valid_n, need_div, neg_n;
	logic [8:0]               k_n;
	logic signed [23:0]       gap_n;
	// divider
	logic [30:0]              rcp;
	logic [60:0]              prod;
	logic [23:0]              dq;
	logic signed [23:0]       div_gap;
	// list tracking
	logic                     upd, seen_n, slot_free;
	logic [23:0]              best_pos_n;
	logic [15:0]              best_id_n, held_n;

	assign job_pop   = (state_q == S_IDLE) && job_valid;
	assign empty     = !out_valid_q;
	assign result    = out_q;
	assign slot_free = !out_valid_q || pop;

	assign w      = job_q.vt2 - job_q.ve2;
	assign mul_op = (state_q == S_SQ1) ? ((job_q.kind == K_Z1_QUAD) ? job_q.ve2 : w)
	                                   : job_q.vt2;
	assign mul_x  = PW'(mul_op);
	assign mul_p  = mul_x * mul_x;

	assign b48  = NUM_W'(job_q.base8);
	assign ve48 = NUM_W'(job_q.ve2);
	assign w48  = NUM_W'(w);
	assign d48  = NUM_W'(job_q.gap);

	always_comb begin
		unique case (job_q.kind)
			K_Z0, K_Z1_LIN, K_Z2_LIN: num_n = b48;
			K_Z1_QUAD: num_n = ((b48 * C35) <<< FRAC_BITS) + ((ve48 * C252) <<< FRAC_BITS)
			                   + (NUM_W'(p1_q) - NUM_W'(p2_q)) * C5;
			K_Z2_QUAD: num_n = ((b48 * C10) <<< FRAC_BITS) + NUM_W'(p1_q) * C5
			                   + ((w48 * C72) <<< FRAC_BITS);
			default:   num_n = '0;
		endcase
	end

	// compare gap * denominator against the exact numerator
	assign z1q  = job_q.kind == K_Z1_QUAD;
	assign quad = z1q || (job_q.kind == K_Z2_QUAD);
	always_comb begin
		unique case (job_q.kind)
			K_Z1_QUAD: lhs = (d48 * C280) <<< FRAC_BITS;
			K_Z2_QUAD: lhs = (d48 * C80) <<< FRAC_BITS;
			default:   lhs = d48 <<< 3;
		endcase
	end
	assign cmp = lhs < num_q;

	always_comb begin
		unique case (job_q.kind)
			K_Z0:                                     danger_n = cmp;
			K_Z1_FIX:                                 danger_n = job_q.fix_danger;
			K_Z1_LIN, K_Z1_QUAD, K_Z2_LIN, K_Z2_QUAD: danger_n = cmp && job_q.near_ok;
			default:                                  danger_n = 1'b0;
		endcase
	end
	assign valid_n = danger_n || (job_q.kind == K_Z1_FIX);

	// rounding, ties up: floor((num + dn/2) / dn); dn = K * 2^FRAC_BITS on quad paths
	assign r8  = (num_q + NUM_W'(4)) >>> 3;
	assign k_n = z1q ? 9'd280 : 9'd80;
	assign xr  = num_q + (z1q ? H140 : H40);
	assign yr  = xr >>> FRAC_BITS;
	assign neg_n = yr < 0;
	assign m   = neg_n ? NUM_W'(-yr + NUM_W'(k_n) - NUM_W'(1)) : NUM_W'(yr);
	assign lim = NUM_W'(k_n) << 24;
	assign need_div = valid_n && quad && (m < lim);

	always_comb begin
		priority if (!valid_n)
			gap_n = '0;
		else if (job_q.kind == K_Z1_FIX)
			gap_n = GAP100;
		else if (quad)
			gap_n = neg_n ? 24'(MIN24) : 24'(MAX24);   // overflow; replaced when dividing
		else if (r8 > MAX24)
			gap_n = 24'(MAX24);
		else if (r8 < MIN24)
			gap_n = 24'(MIN24);
		else
			gap_n = 24'(r8);
	end

	// m / 280 = (m / 8) / 35, m / 80 = (m / 16) / 5
	assign rcp  = div_z1_q ? RCP35 : RCP5;
	assign prod = divn_q * rcp;
	assign dq   = div_z1_q ? prod[59:36] : prod[53:30];

	always_comb begin
		if (neg_q)
			div_gap = (dq > 24'h800000) ? 24'(MIN24) : 24'(-dq);
		else
			div_gap = dq[23] ? 24'(MAX24) : 24'(dq);
	end

	// nearest dangerous target of the list; earlier wins ties
	always_comb begin
		upd        = danger_q && (!seen_q || job_q.abs_pos < best_pos_q);
		best_pos_n = upd ? job_q.abs_pos : best_pos_q;
		best_id_n  = upd ? job_q.target_id : best_id_q;
		seen_n     = seen_q || danger_q;
		held_n     = (job_q.last && seen_n) ? best_id_n : held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			seen_q      <= 1'b0;
			best_pos_q  <= '0;
			best_id_q   <= '0;
			held_q      <= '0;
		end else begin
			priority if ((state_q == S_OUT) && slot_free)
				out_valid_q <= 1'b1;
			else if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (job_valid) state_q <= S_SQ1;
				S_SQ1:  state_q <= S_SQ2;
				S_SQ2:  state_q <= S_NUM;
				S_NUM:  state_q <= S_CMP;
				S_CMP:  state_q <= need_div ? S_DIV : S_OUT;
				S_DIV:  state_q <= S_OUT;
				S_OUT: begin
					if (slot_free) begin
						held_q <= held_n;
						if (job_q.last) begin
							seen_q     <= 1'b0;
							best_pos_q <= '0;
							best_id_q  <= '0;
						end else begin
							seen_q     <= seen_n;
							best_pos_q <= best_pos_n;
							best_id_q  <= best_id_n;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job;
		if (state_q == S_SQ1)
			p1_q <= mul_p;
		if (state_q == S_SQ2)
			p2_q <= mul_p;
		if (state_q == S_NUM)
			num_q <= num_n;
		if (state_q == S_CMP) begin
			danger_q <= danger_n;
			valid_q  <= valid_n;
			gap_q    <= gap_n;
			neg_q    <= neg_n;
			div_z1_q <= z1q;
			divn_q   <= z1q ? m[32:3] : m[33:4];
		end
		if (state_q == S_DIV)
			gap_q <= div_gap;
		if ((state_q == S_OUT) && slot_free) begin
			out_q.danger         <= danger_q;
			out_q.safe_gap_valid <= valid_q;
			out_q.safe_gap       <= gap_q;
			out_q.list_done      <= job_q.last;
			out_q.warn_flag      <= job_q.last && seen_n;
			out_q.warn_id        <= held_n;
		end
	end

endmodule

>>> sv/lane_change_safe_gap_checker_unit.sv
// Path from push to result: job queue, then the back end sequencer (two squarer passes,
//   numerator, compare, a divide step when a quadratic safe gap needs the divider), then
//   the result register; the sequencer takes the next item only once the last is stored.
// A 2-deep job queue lets push proceed while the result register waits for pop.
// Reset (arst_n low, asynchronous): job queue empty, ego registers and list tracking cleared.
// ----------------------------------------------------------------------------
// Lane change safe gap checker
// Flags targets closer than their kinematic minimum safe gap and reports the
// nearest dangerous target at the end of each list.
// ----------------------------------------------------------------------------
module lane_change_safe_gap_checker_unit import lcsg_pkg::*; #(
	parameter int FRAC_BITS   = 8,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  target_t     target,
	input  logic        push,
	output logic        full,
	output result_t     result,
	output logic        empty,
	input  logic        pop,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic signed [15:0] ego_speed_q, ego_accel_q;
	job_t               front_job, back_job;
	logic               job_valid, job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ego_speed_q <= '0;
			ego_accel_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EGO_SPEED: ego_speed_q <= cfg_data;
				REG_EGO_ACCEL: ego_accel_q <= cfg_data;
			endcase
		end
	end

	lcsg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.target    (target),
		.ego_speed (ego_speed_q),
		.ego_accel (ego_accel_q),
		.job       (front_job)
	);

	lcsg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_data   (front_job),
		.full      (full),
		.rd_en     (job_pop),
		.rd_data   (back_job),
		.not_empty (job_valid)
	);

	lcsg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

>>> sv/lcsg_chk.sv
// ----------------------------------------------------------------------------
// Lane change safe gap checker: port checker
// Result consistency and output hold rules, bound to the top level.
// ----------------------------------------------------------------------------
`include "lane_change_safe_gap_checker_unit_defines.svh"

module lcsg_chk import lcsg_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input result_t result,
	input logic    empty,
	input logic    pop
);

	`LCSG_ASSERT_NOW(a_warn_at_end, !empty && !result.list_done, !result.warn_flag, "warn_flag off list end")
	`LCSG_ASSERT_NOW(a_gap_zero, !empty && !result.safe_gap_valid, result.safe_gap == 24'sd0, "gap without valid")
	`LCSG_ASSERT_NOW(a_danger_gap, !empty && result.danger, result.safe_gap_valid, "danger without gap")
	`LCSG_ASSERT_NOW(a_danger_warn, !empty && result.danger && result.list_done, result.warn_flag, "missed warning")
	`LCSG_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result changed while held")

endmodule

bind lane_change_safe_gap_checker_unit lcsg_chk u_chk (.*);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lane change safe gap checker: testbench
// Random and directed target lists against an in-bench safe gap predictor;
// results are compared as whole records in arrival order.
// ----------------------------------------------------------------------------
module tb;
	import lcsg_pkg::*;

	localparam int ONE = 256;
	localparam int LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	target_t     target;
	logic        push;
	logic        full;
	result_t     result;
	logic        empty;
	logic        pop;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	lane_change_safe_gap_checker_unit dut (
		.clk(clk), .arst_n(arst_n), .target(target), .push(push), .full(full),
		.result(result), .empty(empty), .pop(pop), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// predictor state
	logic signed [15:0] ego_v, ego_a;
	logic [23:0] best_pos;
	logic [15:0] best_tid, warn_hold;
	logic        any_danger;

	target_t pending_targets[$];
	result_t expected_results[$];
	int errors = 0;
	int cycles = 0;

	function automatic longint rnd_div(longint n, longint d);
		longint x, q;
		x = n + d / 2;
		q = x / d;
		if ((x % d) != 0 && x < 0) q--;
		return q;
	endfunction

	function automatic result_t predict_gap(target_t t);
		result_t r;
		longint d, u, b, x, v, a, vt2, ve2, den, num, dn, base8, w, g, ad, aden, ax;
		logic dng, vld, fix, ttc;
		d = t.target_gap; u = t.target_speed; b = t.target_accel;
		x = t.target_pos_x; v = ego_v; a = ego_a;
		vt2 = 2 * u + 3 * b; ve2 = 2 * v + 3 * a; den = u - v;
		num = 0; dn = 8; dng = 0; vld = 0; fix = 0; ttc = 0;
		if (t.zone == 2'd0) begin
			num = 87 * ONE + 12 * v + 9 * a - 12 * u;
			dng = d * dn < num;
		end else if (t.zone == 2'd1) begin
			if (u < 0) begin
				fix = 1; vld = 1; dng = d < 50 * ONE;
			end else begin
				base8 = 24 * ONE + 12 * v + 9 * a - 12 * u - 9 * b;
				if (vt2 > ve2) begin
					num = base8;
				end else begin
					dn = 280 * ONE;
					num = base8 * 35 * ONE + ve2 * 252 * ONE + (ve2 * ve2 - vt2 * vt2) * 5;
				end
				if (den != 0) begin
					ad = d < 0 ? -d : d;
					aden = den < 0 ? -den : den;
					ttc = 2 * ad < 15 * aden;
				end
				dng = d * dn < num && (d < 30 * ONE || ttc);
			end
		end else if (t.zone == 2'd2) begin
			base8 = 24 * ONE - 12 * v - 9 * a + 12 * u + 9 * b;
			if (vt2 < ve2) begin
				num = base8;
			end else begin
				w = vt2 - ve2;
				dn = 80 * ONE;
				num = base8 * 10 * ONE + w * w * 5 + 72 * w * ONE;
			end
			if (den > 0) ttc = 2 * d < 15 * den;
			else if (den < 0) ttc = 2 * d > 15 * den;
			else ttc = d < 0;
			dng = d * dn < num && (d < 30 * ONE || ttc);
		end
		if (dng) vld = 1;
		g = 0;
		if (vld) begin
			if (fix) g = 100 * ONE;
			else begin
				g = rnd_div(num, dn);
				if (g > 8388607) g = 8388607;
				if (g < -8388608) g = -8388608;
			end
		end
		if (dng) begin
			ax = x < 0 ? -x : x;
			if (!any_danger || ax[23:0] < best_pos) begin
				best_pos = ax[23:0];
				best_tid = t.target_id;
			end
			any_danger = 1;
		end
		r.warn_flag = 0;
		if (t.last_target) begin
			r.warn_flag = any_danger;
			if (any_danger) warn_hold = best_tid;
			any_danger = 0; best_pos = '0; best_tid = '0;
		end
		r.danger = dng;
		r.safe_gap_valid = vld;
		r.safe_gap = g[23:0];
		r.list_done = t.last_target;
		r.warn_id = warn_hold;
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	function automatic logic gap_len_zero();
		return $urandom_range(0, 2) != 0;
	endfunction

	// full sampled at the rising edge
	logic full_s = 0;

	// driver
	int push_wait = 0;
	logic hold_off = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (push && !full_s) begin
				expected_results = {expected_results, predict_gap(target)};
				void'(pending_targets.pop_front());
				push_wait <= gap_len();
			end else if (!push && push_wait > 0) begin
				push_wait <= push_wait - 1;
			end
			if (pending_targets.size() > 0 && !hold_off &&
			    ((push && !full_s) ? gap_len_zero() : (push || push_wait <= 1))) begin
				push <= 1'b1;
				target <= pending_targets[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		full_s <= full;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) $display("unexpected result %p", result);
				end else begin
					if (result !== expected_results[0]) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: exp %p got %p", expected_results[0], result);
					end
					void'(expected_results.pop_front());
				end
			end
		end
	end

	// result side stall
	int pop_wait = 0;
	always @(negedge clk) begin
		if (pop_wait > 0) begin
			pop_wait <= pop_wait - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 5) == 0) pop_wait <= gap_len();
		end
	end

	task automatic wait_drained();
		while (pending_targets.size() > 0 || push || expected_results.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_EGO_SPEED) ego_v = val;
		else ego_a = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic target_t rand_target(logic last);
		target_t t;
		t.zone = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
		t.target_id = 16'($urandom);
		case ($urandom_range(0, 3))
			0: t.target_gap = 24'($urandom);
			default: t.target_gap = 24'($signed($urandom_range(0, 30000)) - 2000);
		endcase
		if ($urandom_range(0, 3) == 0) begin
			t.target_speed = 16'($urandom);
			t.target_accel = 16'($urandom);
		end else begin
			t.target_speed = 16'($signed($urandom_range(0, 16000)) - 3000);
			t.target_accel = 16'($signed($urandom_range(0, 2000)) - 1000);
		end
		t.target_pos_x = 24'($urandom);
		t.last_target = last;
		return t;
	endfunction

	task automatic add_list(int n);
		for (int i = 0; i < n; i++)
			pending_targets = {pending_targets, rand_target(i == n - 1)};
	endtask

	logic [15:0] ego_set[6] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0a00, 16'hfe00, 16'h1400};

	initial begin
		target_t t;
		target = '0; push = 0; pop = 0; cfg_valid = 0; cfg_index = REG_EGO_SPEED;
		cfg_data = '0; arst_n = 0;
		ego_v = 0; ego_a = 0; best_pos = 0; best_tid = 0; warn_hold = 0; any_danger = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, each zone, receding front target, equal speeds
		for (int z = 0; z < 4; z++) begin
			t = '0; t.zone = 2'(z); t.target_id = 16'(z + 1);
			t.target_gap = 24'h800000; t.target_speed = 16'h7fff; t.target_accel = 16'h8000;
			t.target_pos_x = 24'h7fffff;
			pending_targets = {pending_targets, t};
			t.target_gap = 24'h7fffff; t.target_speed = 16'h8000; t.target_accel = 16'h7fff;
			t.target_pos_x = 24'h800000; t.target_id = 16'hffff;
			pending_targets = {pending_targets, t};
			t.target_gap = 24'(-100); t.target_speed = 0; t.target_accel = 0;
			t.target_pos_x = 24'(-5); t.target_id = 16'h1234;
			pending_targets = {pending_targets, t};
		end
		t = '0; t.zone = 2'd1; t.target_speed = 16'hff00; t.target_gap = 24'(40 * ONE);
		pending_targets = {pending_targets, t};
		t.target_gap = 24'(60 * ONE); t.last_target = 1; t.target_id = 16'h0bad;
		pending_targets = {pending_targets, t};
		t = '0; t.zone = 2'd2; t.target_gap = 24'(10 * ONE); t.last_target = 1;
		pending_targets = {pending_targets, t};
		wait_drained();
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_EGO_SPEED, ego_set[p]);
			write_reg(REG_EGO_ACCEL, ego_set[(p + 3) % 6]);
			for (int k = 0; k < 55; k++) add_list($urandom_range(1, 8));
			// mid-stream, hold off until everything in flight drains
			if (p == 2) begin
				repeat (200) @(negedge clk);
				hold_off = 1;
				while (push || expected_results.size() > 0) @(negedge clk);
				hold_off = 0;
			end
			wait_drained();
		end
		write_reg(REG_EGO_SPEED, 16'($urandom));
		write_reg(REG_EGO_ACCEL, 16'($urandom));
		for (int k = 0; k < 33; k++) add_list($urandom_range(1, 8));
		wait_drained();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
